### src/vnorm_pkg.sv
package vnorm_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COMP_W      = 32;
    localparam int UNIT_W      = 18;
    localparam int LEN_W       = 31;
    localparam int CNT_W       = 3;
    localparam int SCALE_STEP  = 6;
    localparam int SCALED_W    = 40;  // scaled component: |s| < 2^39
    localparam int MAG_W       = 24;  // shifted component: |s| <= 64 * one
    localparam int SQ_W        = 64;  // sum of truncated squares, shifted for root
    localparam int ROOT_W      = 32;
    localparam int RECIP_W     = 33;
    localparam int QUOT_W      = 2 * FRAC_BITS + 1;
    localparam int NUM_COMP    = 4;
    localparam logic [CNT_W-1:0] CNT_RESET = 3'd3;

    // scale shift codes: direction and number of 6-bit steps
    typedef struct packed {
        logic       down;
        logic [2:0] steps;
    } scale_t;

endpackage

### src/vector_normalize_fixed_point.sv
// Fixed-point vector normalizer: accepts one vector of up to four signed
// Q16.16 components per cycle and returns the unit vector (signed Q2.16,
// clamped to +/-1) and the true Euclidean length (saturated, with a flag).
// All-zero input gives a zero result with zero_vector set. The datapath is
// a deep pipeline: scale select, shift, squares, sum, a bit-per-stage square
// root (32 stages), a bit-per-stage restoring divider for the reciprocal
// (33 stages), the unit multiplies and the length rescale. The whole
// pipeline moves only when the output register is empty or being taken, so
// stalls lose and repeat nothing; otherwise throughput is one item per cycle.
// active_components may only be changed while idle.
module vector_normalize_fixed_point (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [vnorm_pkg::CNT_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [vnorm_pkg::COMP_W-1:0]   comp_0,
    input  logic signed [vnorm_pkg::COMP_W-1:0]   comp_1,
    input  logic signed [vnorm_pkg::COMP_W-1:0]   comp_2,
    input  logic signed [vnorm_pkg::COMP_W-1:0]   comp_3,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [vnorm_pkg::UNIT_W-1:0]   unit_0,
    output logic signed [vnorm_pkg::UNIT_W-1:0]   unit_1,
    output logic signed [vnorm_pkg::UNIT_W-1:0]   unit_2,
    output logic signed [vnorm_pkg::UNIT_W-1:0]   unit_3,
    output logic [vnorm_pkg::LEN_W-1:0]           vec_length,
    output logic                                  length_saturated,
    output logic                                  zero_vector
);
    import vnorm_pkg::*;

    localparam int SQRT_N = ROOT_W;
    localparam int DIV_N  = QUOT_W;
    // stage map: 0 scale select, 1 shift, 2 squares, 3 sum,
    // 4..4+SQRT_N-1 root, then divider, then multiply, then output
    localparam int S_ROOT0 = 4;
    localparam int S_DIV0  = S_ROOT0 + SQRT_N;
    localparam int S_MUL   = S_DIV0 + DIV_N;
    localparam int NST     = S_MUL + 1;

    logic [CNT_W-1:0] cnt_reg;
    logic             adv;   // whole pipe steps

    // per stage control and payload
    logic [NST-1:0]             v_reg;
    logic [NUM_COMP-1:0]        act_reg  [NST];
    logic                       zero_reg [NST];
    scale_t                     sc_reg   [NST];
    logic signed [SCALED_W-1:0] s_reg    [NST][NUM_COMP];
    logic [SQ_W-1:0]            sq_reg   [NST];  // square root remainder
    logic [SQ_W-1:0]            q_reg    [NST];  // square root operand
    logic [ROOT_W-1:0]          root_reg [NST];
    logic [QUOT_W:0]            rem_reg  [NST];
    logic [QUOT_W-1:0]          quo_reg  [NST];
    logic [SQ_W-1:0]            sqs_reg  [NUM_COMP]; // squares at stage 2

    // output register
    logic                     ov_reg;
    logic signed [UNIT_W-1:0] u_reg [NUM_COMP];
    logic [LEN_W-1:0]         len_reg;
    logic                     sat_reg, zv_reg;

    assign adv      = !ov_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= CNT_RESET;
        else if (cfg_we)
            cnt_reg <= cfg_data;
    end

    // stage 0: magnitudes and scale select
    logic signed [COMP_W-1:0] cin [NUM_COMP];
    logic [NUM_COMP-1:0]      act_next;
    logic [COMP_W:0]          mag_max;
    scale_t                   sc_next;
    always_comb
    begin
        logic [COMP_W:0] a;
        cin[0] = comp_0; cin[1] = comp_1; cin[2] = comp_2; cin[3] = comp_3;
        if (cnt_reg <= 3'd2)      act_next = 4'b0011;
        else if (cnt_reg == 3'd3) act_next = 4'b0111;
        else                      act_next = 4'b1111;
        mag_max = '0;
        for (int i = 0; i < NUM_COMP; i++)
        begin
            a = cin[i][COMP_W-1] ? -{cin[i][COMP_W-1], cin[i]} : {1'b0, cin[i]};
            if (act_next[i] && a > mag_max)
                mag_max = a;
        end
        sc_next.down = mag_max > (COMP_W+1)'(1 << FRAC_BITS);
        sc_next.steps = 3'd0;
        if (sc_next.down)
        begin
            // m <= 2^22 no shift; each step divides by 64
            if (mag_max[COMP_W:FRAC_BITS+SCALE_STEP+1] == '0 &&
                mag_max <= (COMP_W+1)'(1 << (FRAC_BITS+SCALE_STEP)))
                sc_next.steps = 3'd0;
            else if ((mag_max >> 6) <= (COMP_W+1)'(1 << (FRAC_BITS+SCALE_STEP)))
                sc_next.steps = 3'd1;
            else
                sc_next.steps = 3'd2;
        end
        else
        begin
            if (mag_max >= (COMP_W+1)'(1 << FRAC_BITS))       sc_next.steps = 3'd0;
            else if (mag_max >= (COMP_W+1)'(1 << (FRAC_BITS-6))) sc_next.steps = 3'd1;
            else if (mag_max >= (COMP_W+1)'(1 << (FRAC_BITS-12))) sc_next.steps = 3'd2;
            else                                              sc_next.steps = 3'd3;
        end
    end

    // stage 1 shift, stage 2 squares, stage 3 sum, then root and divide
    logic signed [SCALED_W-1:0] sh_next [NUM_COMP];
    always_comb
    begin
        logic [5:0] k;
        k = 6'(sc_reg[0].steps) * 6'(SCALE_STEP);
        for (int i = 0; i < NUM_COMP; i++)
        begin
            if (!act_reg[0][i])
                sh_next[i] = '0;
            else if (sc_reg[0].down)
                sh_next[i] = s_reg[0][i] >>> k;
            else
                sh_next[i] = s_reg[0][i] <<< k;
        end
    end

    // square root step per stage (restoring, one result bit)
    function automatic void sqrt_step(input logic [SQ_W-1:0] rem_in,
                                      input logic [ROOT_W-1:0] r_in,
                                      input logic [SQ_W-1:0] op,
                                      input int bitn,
                                      output logic [SQ_W-1:0] rem_out,
                                      output logic [ROOT_W-1:0] r_out);
        logic [SQ_W+1:0] rr;
        logic [SQ_W+1:0] trial;
        rr    = {rem_in, op[2*bitn+1 -: 2]};
        trial = {(SQ_W+2-ROOT_W-2)'(0), r_in, 2'b01};
        if (rr >= trial)
        begin
            rem_out = SQ_W'(rr - trial);
            r_out   = {r_in[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_out = SQ_W'(rr);
            r_out   = {r_in[ROOT_W-2:0], 1'b0};
        end
    endfunction

    // valid bits step with the pipe; the divider's dividend is 2^(2F), one bit at 2F
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg  <= {v_reg[NST-2:0], in_valid};
            ov_reg <= v_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 0
            act_reg[0]  <= act_next;
            zero_reg[0] <= (mag_max == '0);
            sc_reg[0]   <= sc_next;
            for (int i = 0; i < NUM_COMP; i++)
                s_reg[0][i] <= SCALED_W'(cin[i]);
            // stage 1
            act_reg[1] <= act_reg[0]; zero_reg[1] <= zero_reg[0];
            sc_reg[1]  <= sc_reg[0];
            for (int i = 0; i < NUM_COMP; i++)
                s_reg[1][i] <= sh_next[i];
            // stage 2: truncated squares, shifted value fits MAG_W bits
            act_reg[2] <= act_reg[1]; zero_reg[2] <= zero_reg[1];
            sc_reg[2]  <= sc_reg[1];
            for (int i = 0; i < NUM_COMP; i++)
            begin
                logic signed [MAG_W-1:0]   sm;
                logic signed [2*MAG_W-1:0] sp;
                sm = s_reg[1][i][MAG_W-1:0];
                sp = sm * sm;
                s_reg[2][i] <= s_reg[1][i];
                sqs_reg[i]  <= SQ_W'(sp >>> FRAC_BITS);
            end
            // stage 3: sum, shifted into root operand
            act_reg[3] <= act_reg[2]; zero_reg[3] <= zero_reg[2];
            sc_reg[3]  <= sc_reg[2];
            for (int i = 0; i < NUM_COMP; i++)
                s_reg[3][i] <= s_reg[2][i];
            q_reg[3]    <= (sqs_reg[0] + sqs_reg[1] + sqs_reg[2] + sqs_reg[3])
                           << FRAC_BITS;
            sq_reg[3]   <= '0;
            root_reg[3] <= '0;
            // root stages
            for (int j = 0; j < SQRT_N; j++)
            begin
                logic [SQ_W-1:0]   rem_o;
                logic [ROOT_W-1:0] root_o;
                act_reg[S_ROOT0+j]  <= act_reg[S_ROOT0+j-1];
                zero_reg[S_ROOT0+j] <= zero_reg[S_ROOT0+j-1];
                sc_reg[S_ROOT0+j]   <= sc_reg[S_ROOT0+j-1];
                q_reg[S_ROOT0+j]    <= q_reg[S_ROOT0+j-1];
                for (int i = 0; i < NUM_COMP; i++)
                    s_reg[S_ROOT0+j][i] <= s_reg[S_ROOT0+j-1][i];
                sqrt_step(sq_reg[S_ROOT0+j-1], root_reg[S_ROOT0+j-1],
                          q_reg[S_ROOT0+j-1], SQRT_N-1-j,
                          rem_o, root_o);
                sq_reg[S_ROOT0+j]   <= rem_o;
                root_reg[S_ROOT0+j] <= root_o;
            end
            // divider stages: 2^(2F) / root, one quotient bit each
            for (int j = 0; j < DIV_N; j++)
            begin
                logic [QUOT_W:0] rr;
                logic [QUOT_W:0] pr;
                logic [QUOT_W-1:0] pq;
                pr = (j == 0) ? '0 : rem_reg[S_DIV0+j-1];
                pq = (j == 0) ? '0 : quo_reg[S_DIV0+j-1];
                rr = {pr[QUOT_W-1:0], (DIV_N-1-j == 2*FRAC_BITS)};
                act_reg[S_DIV0+j]  <= act_reg[S_DIV0+j-1];
                zero_reg[S_DIV0+j] <= zero_reg[S_DIV0+j-1];
                sc_reg[S_DIV0+j]   <= sc_reg[S_DIV0+j-1];
                root_reg[S_DIV0+j] <= root_reg[S_DIV0+j-1];
                for (int i = 0; i < NUM_COMP; i++)
                    s_reg[S_DIV0+j][i] <= s_reg[S_DIV0+j-1][i];
                // a zero vector has root 0, its quotient is never used
                if (rr >= (QUOT_W+1)'(root_reg[S_DIV0+j-1]))
                begin
                    rem_reg[S_DIV0+j] <= rr - (QUOT_W+1)'(root_reg[S_DIV0+j-1]);
                    quo_reg[S_DIV0+j] <= {pq[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[S_DIV0+j] <= rr;
                    quo_reg[S_DIV0+j] <= {pq[QUOT_W-2:0], 1'b0};
                end
            end
            // multiply stage: reciprocal is at most one, so 17 bits
            act_reg[S_MUL]  <= act_reg[S_MUL-1];
            zero_reg[S_MUL] <= zero_reg[S_MUL-1];
            sc_reg[S_MUL]   <= sc_reg[S_MUL-1];
            root_reg[S_MUL] <= root_reg[S_MUL-1];
            for (int i = 0; i < NUM_COMP; i++)
            begin
                logic signed [MAG_W-1:0]           sm;
                logic signed [MAG_W+FRAC_BITS+1:0] mp;
                sm = s_reg[S_MUL-1][i][MAG_W-1:0];
                mp = sm * $signed({1'b0, quo_reg[S_MUL-1][FRAC_BITS:0]});
                s_reg[S_MUL][i] <= SCALED_W'(mp >>> FRAC_BITS);
            end
        end
    end

    // output formatting: clamp units, rescale length
    always_ff @(posedge clk)
    begin
        logic [5:0]  k;
        logic [63:0] l;
        if (adv)
        begin
            k = 6'(sc_reg[NST-1].steps) * 6'(SCALE_STEP);
            for (int i = 0; i < NUM_COMP; i++)
            begin
                if (zero_reg[NST-1] || !act_reg[NST-1][i])
                    u_reg[i] <= '0;
                else if (s_reg[NST-1][i] > SCALED_W'(1 << FRAC_BITS))
                    u_reg[i] <= UNIT_W'(1 << FRAC_BITS);
                else if (s_reg[NST-1][i] < -SCALED_W'(1 << FRAC_BITS))
                    u_reg[i] <= -UNIT_W'(1 << FRAC_BITS);
                else
                    u_reg[i] <= UNIT_W'(s_reg[NST-1][i]);
            end
            if (sc_reg[NST-1].down)
                l = 64'(root_reg[NST-1]) << k;
            else
                l = 64'(root_reg[NST-1]) >> k;
            zv_reg <= zero_reg[NST-1];
            if (zero_reg[NST-1])
            begin
                len_reg <= '0; sat_reg <= 1'b0;
            end
            else if (l[63:LEN_W] != '0)
            begin
                len_reg <= '1; sat_reg <= 1'b1;
            end
            else
            begin
                len_reg <= l[LEN_W-1:0]; sat_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = ov_reg;
    assign unit_0           = u_reg[0];
    assign unit_1           = u_reg[1];
    assign unit_2           = u_reg[2];
    assign unit_3           = u_reg[3];
    assign vec_length       = len_reg;
    assign length_saturated = sat_reg;
    assign zero_vector      = zv_reg;

endmodule
